// ----- hdl/tdq_pkg.sv -----
// ---------------------------------------------------------------------------
// Timer queue package
// Types and codes shared by the sorted deadline timer queue and its cells.
// ---------------------------------------------------------------------------
package tdq_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [2:0] KIND_ADDED   = 3'd0;
   localparam logic [2:0] KIND_FULL    = 3'd1;
   localparam logic [2:0] KIND_DELETE  = 3'd2;
   localparam logic [2:0] KIND_EXPIRED = 3'd3;
   localparam logic [2:0] KIND_NONE    = 3'd4;
   localparam logic [2:0] KIND_SLEEP   = 3'd5;

   // Upper bound on timers popped by one expire command.
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = $clog2(MAX_RESULTS);

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [23:0] delay_ms;
      logic [31:0] target_id;
      logic [31:0] target_deadline;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] timer_id;
      logic [31:0] deadline;
      logic        found;
      logic [31:0] sleep_ms;
      logic        queue_empty;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] deadline;
      logic [31:0] ident;
   } entry_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic        insert;
      logic        remove;
      logic [31:0] deadline;
      logic [31:0] ident;
   } cell_ctrl_type;

endpackage

// ----- hdl/tdq_cell.sv -----
// ---------------------------------------------------------------------------
// Timer queue cell
// One slot of the sorted chain; compares the broadcast key with its own entry
// and takes the entry of a neighbor when the chain shifts.
// ---------------------------------------------------------------------------
module tdq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tdq_pkg::cell_ctrl_type ctrl,
   input  tdq_pkg::entry_type     left_entry,
   input  logic                   left_ahead,
   input  tdq_pkg::entry_type     right_entry,
   input  logic                   shift_in,
   output tdq_pkg::entry_type     entry,
   output logic                   key_ahead,
   output logic                   shift_out
);

   tdq_pkg::entry_type entry_ff;
   tdq_pkg::entry_type entry_in;
   logic               match;

   always_comb begin
      key_ahead = !entry_ff.valid
               || (ctrl.deadline < entry_ff.deadline)
               || ((ctrl.deadline == entry_ff.deadline) && (ctrl.ident < entry_ff.ident));
      match = entry_ff.valid && (ctrl.deadline == entry_ff.deadline)
            && (ctrl.ident == entry_ff.ident);
      shift_out = shift_in | match;

      entry_in = entry_ff;
      if (ctrl.insert && key_ahead) begin
         // The first cell that sorts after the key takes it; the rest shift right.
         if (left_ahead) begin
            entry_in = left_entry;
         end else begin
            entry_in.valid    = 1'b1;
            entry_in.deadline = ctrl.deadline;
            entry_in.ident    = ctrl.ident;
         end
      end else if (ctrl.remove && shift_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ----- hdl/sorted_deadline_timer_queue.sv -----
// ---------------------------------------------------------------------------
// Sorted deadline timer queue
// Holds up to CAPACITY timers in a chain of cells sorted by deadline, then id.
// ---------------------------------------------------------------------------
// Usage: a command beat on req_ carries an opcode and the current time. The
// block answers on rsp_ with one beat per result; the final beat of a command
// has last set. Add returns the new id and deadline (or a full indication),
// delete returns whether the timer was found, query returns the time left to
// the earliest deadline, and expire returns one beat per due timer in order
// (up to 32 per command) or a single "none expired" beat.
// Timing: a command is taken in the idle state and executed in the exec state,
// where add, delete, query and an expire with nothing due each produce their
// single beat. An expire pops one timer per cycle while rsp_ is not stalled,
// since each pop shifts the whole chain by one cell and the new head is needed
// before the next pop can be judged. The result beat appears in the cycle
// after the execute cycle, from the output register.
// req_stall is high from the cycle after a command is taken until its last
// result has been written into the output register. A stall on rsp_ holds
// the current beat and freezes execution; nothing is lost.
// Reset clears every valid bit and the id counter, leaving the store empty;
// the block can take a command in the first cycle after reset.
// ---------------------------------------------------------------------------
module sorted_deadline_timer_queue #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tdq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tdq_pkg::rsp_type rsp_payload
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                   state_ff, state_in;
   tdq_pkg::req_type            cmd_ff, cmd_in;
   logic [31:0]                 next_ident_ff, next_ident_in;
   logic [tdq_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tdq_pkg::rsp_type            rsp_ff, rsp_in;

   tdq_pkg::cell_ctrl_type      ctrl;
   tdq_pkg::entry_type          entries [CAPACITY];
   logic [CAPACITY-1:0]         key_ahead;
   logic [CAPACITY-1:0]         shift;

   logic        out_free;
   logic        fire;
   logic [31:0] add_deadline;
   logic        full;
   logic        any_match;
   logic        head_due;
   logic        next_due;
   logic        pop;

   // The chain: cell 0 holds the earliest timer, valid entries stay packed
   // at the low end. An insert shifts right from the insertion point, a
   // delete or pop shifts left from the removed cell.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      tdq_pkg::entry_type left_entry;
      tdq_pkg::entry_type right_entry;
      logic               left_ahead;
      logic               shift_in;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_ahead = 1'b0;
         assign shift_in   = pop;
      end else begin : g_mid
         assign left_entry = entries[i-1];
         assign left_ahead = key_ahead[i-1];
         assign shift_in   = shift[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      tdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_ahead  (left_ahead),
         .right_entry (right_entry),
         .shift_in    (shift_in),
         .entry       (entries[i]),
         .key_ahead   (key_ahead[i]),
         .shift_out   (shift[i])
      );
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      fire         = (state_ff == ST_EXEC) && out_free;
      add_deadline = cmd_ff.now_ms + {8'd0, cmd_ff.delay_ms};
      full         = entries[CAPACITY-1].valid;
      // With no pop feeding the chain, the last shift flag is the OR of all
      // key matches: a duplicate on add, a hit on delete.
      any_match    = shift[CAPACITY-1];
      head_due     = entries[0].valid && (entries[0].deadline <= cmd_ff.now_ms);
      next_due     = entries[1].valid && (entries[1].deadline <= cmd_ff.now_ms);
      pop          = fire && (cmd_ff.opcode == tdq_pkg::OP_EXPIRE) && head_due;

      ctrl.insert   = fire && (cmd_ff.opcode == tdq_pkg::OP_ADD) && !full && !any_match;
      ctrl.remove   = pop || (fire && (cmd_ff.opcode == tdq_pkg::OP_DELETE));
      ctrl.deadline = (cmd_ff.opcode == tdq_pkg::OP_ADD) ? add_deadline
                                                         : cmd_ff.target_deadline;
      ctrl.ident    = (cmd_ff.opcode == tdq_pkg::OP_ADD) ? next_ident_ff
                                                         : cmd_ff.target_id;

      rsp_in      = '0;
      rsp_in.last = 1'b1;
      case (cmd_ff.opcode)
         tdq_pkg::OP_ADD: begin
            if (full) begin
               rsp_in.kind = tdq_pkg::KIND_FULL;
            end else begin
               rsp_in.kind     = tdq_pkg::KIND_ADDED;
               rsp_in.timer_id = next_ident_ff;
               rsp_in.deadline = add_deadline;
            end
         end
         tdq_pkg::OP_DELETE: begin
            rsp_in.kind  = tdq_pkg::KIND_DELETE;
            rsp_in.found = any_match;
         end
         tdq_pkg::OP_EXPIRE: begin
            if (head_due) begin
               rsp_in.kind     = tdq_pkg::KIND_EXPIRED;
               rsp_in.timer_id = entries[0].ident;
               rsp_in.deadline = entries[0].deadline;
               rsp_in.last     = (cnt_ff == tdq_pkg::CNT_W'(tdq_pkg::MAX_RESULTS - 1))
                              || !next_due;
            end else begin
               rsp_in.kind = tdq_pkg::KIND_NONE;
            end
         end
         tdq_pkg::OP_QUERY: begin
            rsp_in.kind        = tdq_pkg::KIND_SLEEP;
            rsp_in.queue_empty = !entries[0].valid;
            if (entries[0].valid && (entries[0].deadline > cmd_ff.now_ms)) begin
               rsp_in.sleep_ms = entries[0].deadline - cmd_ff.now_ms;
            end
         end
         default: begin
            rsp_in.kind = tdq_pkg::KIND_NONE;
         end
      endcase

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      next_ident_in = next_ident_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (state_ff == ST_IDLE) begin
         if (req_valid) begin
            state_in = ST_EXEC;
            cmd_in   = req_payload;
            cnt_in   = '0;
         end
      end else if (fire) begin
         rsp_valid_in = 1'b1;
         cnt_in       = cnt_ff + 1'b1;
         if ((cmd_ff.opcode == tdq_pkg::OP_ADD) && !full) begin
            next_ident_in = next_ident_ff + 32'd1;
         end
         if (rsp_in.last) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_ident_ff <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_ident_ff <= next_ident_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- hdl/tdq_checker.sv -----
// ---------------------------------------------------------------------------
// Timer queue checker
// Port-level properties of the sorted deadline timer queue.
// ---------------------------------------------------------------------------
module tdq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tdq_pkg::rsp_type rsp_payload
);

   // A taken command blocks the input until its results are produced.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a command beat");

   // The input reopens only together with the final beat of a command.
   a_reopen_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid && rsp_payload.last)
      else $error("input reopened without a final result beat");

   // Only expired-timer beats may leave last clear.
   a_single_beat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != tdq_pkg::KIND_EXPIRED) |-> rsp_payload.last)
      else $error("single result without last");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

endmodule

bind sorted_deadline_timer_queue tdq_checker u_tdq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
